// File: sv/bresenham_line_rasterizer_core_defines.svh
// assertion helpers used by the rasterizer controller
`ifndef BRESENHAM_LINE_RASTERIZER_CORE_DEFINES_SVH
`define BRESENHAM_LINE_RASTERIZER_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define BLR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define BLR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/blr_pkg.sv
`timescale 1ns / 1ps

package blr_pkg;

  // field widths of the item ports
  localparam int unsigned CoordW            = 6;
  localparam int unsigned ColorW            = 32;
  localparam int unsigned CoordBitsDefault  = 6;

  // input item: one segment
  typedef struct packed {
    logic [CoordW-1:0] start_x;
    logic [CoordW-1:0] start_y;
    logic [CoordW-1:0] end_x;
    logic [CoordW-1:0] end_y;
    logic [ColorW-1:0] line_color;
  } in_item_t;

  // output item: one pixel write
  typedef struct packed {
    logic [CoordW-1:0] pixel_x;
    logic [CoordW-1:0] pixel_y;
    logic [ColorW-1:0] pixel_color;
    logic              last_pixel;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;   // capture the segment endpoints and color
    logic setup;  // order endpoints, load deltas and decision term
    logic step;   // advance to the next pixel
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;  // segment has no pixels
    logic last;   // current pixel is the final one
  } status_t;

endpackage

// File: sv/blr_ctrl.sv
`timescale 1ns / 1ps
`include "bresenham_line_rasterizer_core_defines.svh"

module blr_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output blr_pkg::cmd_t    cmd_o,
  input  blr_pkg::status_t status_i
);

  typedef enum logic [1:0] {
    StIdle,
    StSetup,
    StRun
  } state_e;

  state_e state_q;
  logic   in_ready_q;
  logic   out_valid_q;

  // commands from state and handshakes
  always_comb begin
    cmd_o.load  = in_valid_i && in_ready_q;
    cmd_o.setup = (state_q == StSetup);
    cmd_o.step  = out_valid_q && out_ready_i;
  end

  // sequencer with registered handshake outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      in_ready_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        StIdle: begin
          if (in_valid_i && in_ready_q) begin
            state_q    <= StSetup;
            in_ready_q <= 1'b0;
          end else begin
            in_ready_q <= 1'b1;
          end
        end
        StSetup: begin
          if (status_i.empty) begin
            state_q    <= StIdle;
            in_ready_q <= 1'b1;
          end else begin
            state_q     <= StRun;
            out_valid_q <= 1'b1;
          end
        end
        StRun: begin
          if (out_valid_q && out_ready_i && status_i.last) begin
            state_q     <= StIdle;
            out_valid_q <= 1'b0;
            in_ready_q  <= 1'b1;
          end
        end
        default: begin
          state_q     <= StIdle;
          in_ready_q  <= 1'b0;
          out_valid_q <= 1'b0;
        end
      endcase
    end
  end

  assign in_ready_o  = in_ready_q;
  assign out_valid_o = out_valid_q;

  `BLR_ASSERT_SAME(a_ready_valid_excl, clk_i, rst_ni, 1'b1, !(in_ready_q && out_valid_q), "in ready while a pixel is pending")
  `BLR_ASSERT_NEXT(a_accept_to_setup, clk_i, rst_ni, in_valid_i && in_ready_q, state_q == StSetup && !in_ready_q && !out_valid_q, "accepted item did not enter setup")
  `BLR_ASSERT_NEXT(a_empty_to_idle, clk_i, rst_ni, state_q == StSetup && status_i.empty, in_ready_q && !out_valid_q, "empty segment produced pixels")
  `BLR_ASSERT_NEXT(a_last_to_idle, clk_i, rst_ni, out_valid_q && out_ready_i && status_i.last, in_ready_q && !out_valid_q, "no return to idle after last pixel")

endmodule

// File: sv/blr_datapath.sv
`timescale 1ns / 1ps

module blr_datapath #(
  parameter int unsigned COORD_BITS = blr_pkg::CoordBitsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  blr_pkg::cmd_t      cmd_i,
  output blr_pkg::status_t   status_o,
  input  blr_pkg::in_item_t  in_item_i,
  output blr_pkg::out_item_t out_item_o
);

  localparam int unsigned DecW   = COORD_BITS + 3;
  localparam int unsigned DeltaW = COORD_BITS + 1;
  localparam int unsigned OutW   = blr_pkg::CoordW;

  typedef logic [COORD_BITS-1:0] coord_t;

  // captured segment
  coord_t                    sx_q, sy_q, ex_q, ey_q;
  logic [blr_pkg::ColorW-1:0] color_q;

  // walk state
  coord_t              major_q, minor_q, end_q;
  logic signed [DecW-1:0] dec_q;
  logic [DeltaW-1:0]   tmaj_q, tmin_q;
  logic                swap_q, up_q;

  // setup terms
  coord_t dx_abs, dy_abs, a_maj, a_min, b_maj, b_min;
  coord_t p_maj, p_min, q_maj, q_min, dmaj, dmin;
  logic   swap_s, rev_s, up_s;
  logic signed [DecW-1:0] dec_init;

  // step terms
  logic                   dec_pos, last_s;
  coord_t                 minor_nx;
  logic signed [DecW-1:0] dec_nx;

  // axis choice, endpoint order and deltas
  always_comb begin
    dx_abs   = (ex_q >= sx_q) ? ex_q - sx_q : sx_q - ex_q;
    dy_abs   = (ey_q >= sy_q) ? ey_q - sy_q : sy_q - ey_q;
    swap_s   = dy_abs > dx_abs;
    a_maj    = swap_s ? sy_q : sx_q;
    a_min    = swap_s ? sx_q : sy_q;
    b_maj    = swap_s ? ey_q : ex_q;
    b_min    = swap_s ? ex_q : ey_q;
    rev_s    = a_maj > b_maj;
    p_maj    = rev_s ? b_maj : a_maj;
    p_min    = rev_s ? b_min : a_min;
    q_maj    = rev_s ? a_maj : b_maj;
    q_min    = rev_s ? a_min : b_min;
    dmaj     = q_maj - p_maj;
    up_s     = q_min > p_min;
    dmin     = up_s ? q_min - p_min : p_min - q_min;
    dec_init = $signed({2'b00, dmin, 1'b0}) - $signed({3'b000, dmaj});
  end

  // one pixel step of the decision term
  always_comb begin
    dec_pos  = !dec_q[DecW-1] && (dec_q != '0);
    minor_nx = up_q ? minor_q + coord_t'(1) : minor_q - coord_t'(1);
    dec_nx   = dec_q + $signed({2'b00, tmin_q});
    if (dec_pos) begin
      dec_nx = dec_nx - $signed({2'b00, tmaj_q});
    end
    last_s   = ({1'b0, major_q} + DeltaW'(1)) == {1'b0, end_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sx_q    <= '0;
      sy_q    <= '0;
      ex_q    <= '0;
      ey_q    <= '0;
      color_q <= '0;
      major_q <= '0;
      minor_q <= '0;
      end_q   <= '0;
      dec_q   <= '0;
      tmaj_q  <= '0;
      tmin_q  <= '0;
      swap_q  <= 1'b0;
      up_q    <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        sx_q    <= in_item_i.start_x[COORD_BITS-1:0];
        sy_q    <= in_item_i.start_y[COORD_BITS-1:0];
        ex_q    <= in_item_i.end_x[COORD_BITS-1:0];
        ey_q    <= in_item_i.end_y[COORD_BITS-1:0];
        color_q <= in_item_i.line_color;
      end
      if (cmd_i.setup) begin
        major_q <= p_maj;
        minor_q <= p_min;
        end_q   <= q_maj;
        dec_q   <= dec_init;
        tmaj_q  <= {dmaj, 1'b0};
        tmin_q  <= {dmin, 1'b0};
        swap_q  <= swap_s;
        up_q    <= up_s;
      end else if (cmd_i.step) begin
        if (dec_pos) begin
          minor_q <= minor_nx;
        end
        dec_q   <= dec_nx;
        major_q <= major_q + coord_t'(1);
      end
    end
  end

  // status and pixel payload
  always_comb begin
    status_o.empty         = (sx_q == ex_q) && (sy_q == ey_q);
    status_o.last          = last_s;
    out_item_o.pixel_x     = OutW'(swap_q ? minor_q : major_q);
    out_item_o.pixel_y     = OutW'(swap_q ? major_q : minor_q);
    out_item_o.pixel_color = color_q;
    out_item_o.last_pixel  = last_s;
  end

endmodule

// File: sv/bresenham_line_rasterizer_core.sv
// first pixel: offered once the setup state that follows the segment's accept
//   has loaded the walk, and taken when out_ready_i is high
// throughput: one pixel per cycle while out_ready_i is high; a segment passes
//   through accept, setup, then one step per pixel, and the next segment is
//   accepted only after its last pixel is taken or, with no pixels, after setup
// reset: rst_ni asynchronous active low, block returns idle with no pixel pending
`timescale 1ns / 1ps

module bresenham_line_rasterizer_core #(
  parameter int unsigned COORD_BITS = blr_pkg::CoordBitsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  blr_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output blr_pkg::out_item_t out_item_o
);

  blr_pkg::cmd_t    cmd;
  blr_pkg::status_t status;

  // sequencer
  blr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  // line walk datapath
  blr_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .in_item_i  (in_item_i),
    .out_item_o (out_item_o)
  );

endmodule
